// File: rtl/rws_pkg.sv
// Shared constants, field widths, command codes and sequencer states for
// the roulette wheel selection block. No dependencies.
`timescale 1ns / 1ps

package rws_pkg;

  // Default depth of the cumulative weight table
  localparam int TABLE_DEPTH_DEF = 64;

  // Field widths fixed by the interface
  localparam int SIZE_W      = 7;
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int SEL_W       = 6;
  localparam int PROD_W      = FRAC_W + VAL_W;

  // Packed word widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // Bit offsets of the input fields inside in_tdata
  localparam int IDX_LSB     = 0;
  localparam int VAL_LSB     = IDX_LSB + IDX_W;
  localparam int FRAC_LSB    = VAL_LSB + VAL_W;

  // Command codes carried on in_tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // Search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_LOW,
    S_HIGH,
    S_DONE
  } st_t;

endpackage

// File: rtl/roulette_wheel_select.sv
// Roulette wheel selection: weighted index pick by binary search over a
// cumulative weight table. Uses rws_pkg and one rws_ram instance.
`timescale 1ns / 1ps

//  channel  | direction | handshake            | word contents
//  ---------+-----------+----------------------+------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tuser: cmd; tdata: index,value,frac
//  out_     | master    | out_tvalid/out_tready| tdata: selected_index
//  cfg_     | write     | cfg_wr_en            | cfg_wr_data: table_size
//
// A load word is written while idle and starts no search. A select word scales the fraction,
// tests entry 0, runs its probes (a second read when entry[p] is read too), hands off the
// result and goes back to idle. Each probe is bound by the single table read port.
// Reset clears only control state; table entries are undefined until loaded. A result
// waiting on out_tready holds the next select in its hand-off cycle, with in_tready low.

module roulette_wheel_select #(
  parameter int TABLE_DEPTH = rws_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: entry_index[5:0], entry_value[37:6], random_fraction[53:38]
  input  logic [rws_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: cmd[0]
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: selected_index[5:0]
  output logic [rws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [rws_pkg::SIZE_W-1:0]        cfg_wr_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int SW    = $clog2(TABLE_DEPTH + 1);
  localparam int SEL_W = rws_pkg::SEL_W;

  // Input word fields
  logic                       in_cmd;
  logic [rws_pkg::IDX_W-1:0]  in_idx;
  logic [rws_pkg::VAL_W-1:0]  in_val;
  logic [rws_pkg::FRAC_W-1:0] in_frac;

  assign in_cmd  = in_tuser;
  assign in_idx  = in_tdata[rws_pkg::IDX_LSB +: rws_pkg::IDX_W];
  assign in_val  = in_tdata[rws_pkg::VAL_LSB +: rws_pkg::VAL_W];
  assign in_frac = in_tdata[rws_pkg::FRAC_LSB +: rws_pkg::FRAC_W];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Registers
  rws_pkg::st_t               st_r, st_nxt;
  logic [rws_pkg::SIZE_W-1:0] size_r;
  logic [rws_pkg::FRAC_W-1:0] frac_r;
  logic [rws_pkg::VAL_W-1:0]  target_r;
  logic [SW-1:0]              lo_r, lo_nxt;
  logic [SW-1:0]              hi_r, hi_nxt;
  logic [AW-1:0]              mid_r, mid_nxt;
  logic [AW-1:0]              res_r, res_nxt;
  logic                       out_valid_r;
  logic [SEL_W-1:0]           out_idx_r;

  // Table port signals
  logic                       ram_we;
  logic [AW-1:0]              rd_addr;
  logic [rws_pkg::VAL_W-1:0]  rd_data;

  // Search control
  logic                       lt, gt;
  logic                       done, cont;
  logic                       out_free, out_load;
  logic [SW-1:0]              n;
  logic [SW:0]                mid_sum;
  logic [rws_pkg::PROD_W-1:0] prod;

  // Table storage
  rws_ram #(
    .WIDTH (rws_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_idx)),
    .wr_data (in_val),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp the configured size into 1..TABLE_DEPTH
  always_comb begin
    if (size_r == '0) begin
      n = SW'(1);
    end else if (int'(size_r) > TABLE_DEPTH) begin
      n = SW'(TABLE_DEPTH);
    end else begin
      n = SW'(size_r);
    end
  end

  // Shared multiplier and comparators
  assign prod = rws_pkg::PROD_W'(frac_r) * rws_pkg::PROD_W'(rd_data);
  assign lt   = target_r < rd_data;
  assign gt   = target_r > rd_data;

  // Search bounds and decision; every probe narrows the bounds or ends the
  // search, so the search ends within the table size
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    res_nxt = res_r;
    done    = 1'b0;
    cont    = 1'b0;
    case (st_r)
      rws_pkg::S_BASE: begin
        lo_nxt = SW'(1);
        hi_nxt = n - SW'(1);
        if (lt || n == SW'(1)) begin
          res_nxt = '0;
          done    = 1'b1;
        end else begin
          cont = 1'b1;
        end
      end
      rws_pkg::S_LOW: begin
        if (lt) begin
          if (hi_r == SW'(mid_r)) begin
            res_nxt = mid_r;
            done    = 1'b1;
          end else begin
            hi_nxt = SW'(mid_r);
            cont   = 1'b1;
          end
        end
      end
      rws_pkg::S_HIGH: begin
        if (gt) begin
          lo_nxt = SW'(mid_r) + SW'(1);
          if (lo_nxt <= hi_r) begin
            cont = 1'b1;
          end else begin
            res_nxt = mid_r;
            done    = 1'b1;
          end
        end else begin
          res_nxt = mid_r;
          done    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Midpoint of the next bounds
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt = AW'(mid_sum[SW:1]);

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rws_pkg::S_IDLE: begin
        if (in_acc && in_cmd == rws_pkg::CMD_SELECT) begin
          st_nxt = rws_pkg::S_MUL;
        end
      end
      rws_pkg::S_MUL: begin
        st_nxt = rws_pkg::S_BASE;
      end
      rws_pkg::S_BASE: begin
        st_nxt = done ? rws_pkg::S_DONE : rws_pkg::S_LOW;
      end
      rws_pkg::S_LOW: begin
        if (done) begin
          st_nxt = rws_pkg::S_DONE;
        end else if (!cont) begin
          st_nxt = rws_pkg::S_HIGH;
        end
      end
      rws_pkg::S_HIGH: begin
        st_nxt = done ? rws_pkg::S_DONE : rws_pkg::S_LOW;
      end
      rws_pkg::S_DONE: begin
        if (out_free) begin
          st_nxt = rws_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = rws_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake, table write and read address
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    rd_addr   = '0;
    unique case (st_r)
      rws_pkg::S_IDLE: begin
        in_tready = 1'b1;
        ram_we    = in_acc && in_cmd == rws_pkg::CMD_LOAD && int'(in_idx) < TABLE_DEPTH;
        rd_addr   = AW'(n - SW'(1));
      end
      rws_pkg::S_MUL: begin
        rd_addr = '0;
      end
      rws_pkg::S_BASE, rws_pkg::S_HIGH: begin
        rd_addr = mid_nxt - AW'(1);
      end
      rws_pkg::S_LOW: begin
        rd_addr = cont ? mid_nxt - AW'(1) : mid_r;
      end
      rws_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rws_pkg::S_IDLE;
      size_r      <= rws_pkg::SIZE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      frac_r <= in_frac;
    end
    if (st_r == rws_pkg::S_MUL) begin
      target_r <= prod[rws_pkg::PROD_W-1:rws_pkg::FRAC_W];
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    res_r <= res_nxt;
    if (cont) begin
      mid_r <= mid_nxt;
    end
    if (out_load) begin
      out_idx_r <= SEL_W'(res_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rws_pkg::OUT_TDATA_W'(out_idx_r);

`ifndef SYNTH
  // The chosen index always lies inside the table in use
  a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rws_pkg::S_DONE |-> SW'(res_r) < n)
    else $error("selected index beyond table size");

  // Search bounds never cross while probing
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rws_pkg::S_LOW || st_r == rws_pkg::S_HIGH) |-> lo_r <= hi_r)
    else $error("search bounds crossed");

  // Probe point stays between the bounds
  a_mid_between: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rws_pkg::S_LOW || st_r == rws_pkg::S_HIGH)
      |-> (SW'(mid_r) >= lo_r && SW'(mid_r) <= hi_r))
    else $error("probe point outside bounds");

  // A load word starts no search
  a_load_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == rws_pkg::CMD_LOAD) |=> st_r == rws_pkg::S_IDLE)
    else $error("load word started a search");
`endif

endmodule

// File: rtl/rws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the cumulative weight table; no package dependencies.
`timescale 1ns / 1ps

module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
